>>> rtl/bqd_pkg.sv
// shared types, constants and control program of the biquad decimator
package bqd_pkg;

  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int COEF_FRAC_BITS_DEF = 14;
  localparam int DECIMATION_DEF     = 2;

  localparam int COEF_W   = 16;
  localparam int NUM_COEF = 5;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;
  localparam int IDX_W    = 3;

  localparam int N_STEPS = 9;
  localparam int STEP_W  = $clog2(N_STEPS);

  typedef enum logic [IDX_W-1:0] {
    REG_A0 = 3'd0,
    REG_A1 = 3'd1,
    REG_A2 = 3'd2,
    REG_B1 = 3'd3,
    REG_B2 = 3'd4
  } reg_idx_e;

  localparam logic signed [COEF_W-1:0] COEF_RESET [NUM_COEF] = '{
    16'sd4799, 16'sd9598, 16'sd4799, 16'sd0, 16'sd2811
  };

  typedef enum logic [2:0] {
    SEL_A0,
    SEL_A1,
    SEL_A2,
    SEL_B1,
    SEL_B2
  } coef_sel_e;

  typedef enum logic {
    OPD_X,
    OPD_Y
  } opd_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_D1,
    ACC_LOAD_D2,
    ACC_LOAD_P,
    ACC_SUB_P
  } acc_op_e;

  typedef struct packed {
    logic      ld_x;
    logic      mul_en;
    coef_sel_e coef_sel;
    opd_sel_e  opd_sel;
    acc_op_e   acc_op;
    logic      y_wr;
    logic      d1_wr;
    logic      d2_wr;
    logic      clr_dly;
  } dp_ctrl_t;

  typedef struct packed {
    logic      wait_in;
    logic      finish;
    logic      mul_en;
    coef_sel_e coef_sel;
    opd_sel_e  opd_sel;
    acc_op_e   acc_op;
    logic      y_wr;
    logic      d1_wr;
    logic      d2_wr;
  } uword_t;

  // control program, one word per step
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '{wait_in: 1'b0, finish: 1'b0, mul_en: 1'b0, coef_sel: SEL_A0,
          opd_sel: OPD_X, acc_op: ACC_HOLD, y_wr: 1'b0, d1_wr: 1'b0, d2_wr: 1'b0};
    unique case (step)
      4'd0: w.wait_in = 1'b1;
      4'd1: begin
        w.mul_en = 1'b1; w.coef_sel = SEL_A0; w.opd_sel = OPD_X;
      end
      4'd2: begin
        w.mul_en = 1'b1; w.coef_sel = SEL_A1; w.opd_sel = OPD_X;
        w.acc_op = ACC_LOAD_D1;
      end
      4'd3: begin
        w.acc_op = ACC_LOAD_D2; w.y_wr = 1'b1;
      end
      4'd4: begin
        w.mul_en = 1'b1; w.coef_sel = SEL_B1; w.opd_sel = OPD_Y;
      end
      4'd5: begin
        w.mul_en = 1'b1; w.coef_sel = SEL_A2; w.opd_sel = OPD_X;
        w.acc_op = ACC_SUB_P;
      end
      4'd6: begin
        w.mul_en = 1'b1; w.coef_sel = SEL_B2; w.opd_sel = OPD_Y;
        w.acc_op = ACC_LOAD_P; w.d1_wr = 1'b1;
      end
      4'd7: w.acc_op = ACC_SUB_P;
      4'd8: begin
        w.d2_wr = 1'b1; w.finish = 1'b1;
      end
      default: w.wait_in = 1'b1;
    endcase
    return w;
  endfunction

endpackage

>>> rtl/bqd_datapath.sv
// shared multiplier, accumulator, delay registers and output rounding with saturation
module bqd_datapath #(
  parameter int SAMPLE_WIDTH   = bqd_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = bqd_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bqd_pkg::dp_ctrl_t                   ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_i,
  input  logic signed [bqd_pkg::COEF_W-1:0]   coef_i [bqd_pkg::NUM_COEF],
  output logic signed [SAMPLE_WIDTH-1:0]      y_o,
  output logic                                clip_o
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int CFB    = COEF_FRAC_BITS;
  localparam int CW     = bqd_pkg::COEF_W;
  localparam int DLY_W  = SW + CFB + 6;
  localparam int ACC_W  = DLY_W + 2;
  localparam int PROD_W = CW + SW;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (CFB - 1);
  localparam logic signed [SW-1:0]    Y_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0]    Y_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [DLY_W-1:0] D_MAX = {1'b0, {(DLY_W-1){1'b1}}};
  localparam logic signed [DLY_W-1:0] D_MIN = {1'b1, {(DLY_W-1){1'b0}}};

  logic signed [SW-1:0]     x_q;
  logic signed [SW-1:0]     y_q;
  logic                     clip_q;
  logic signed [PROD_W-1:0] p_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [DLY_W-1:0]  d1_q, d2_q;

  logic signed [CW-1:0]     coef;
  logic signed [SW-1:0]     opd;
  logic signed [ACC_W-1:0]  p_ext;
  logic signed [ACC_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  ysh;
  logic signed [SW-1:0]     y_sat;
  logic                     y_ovf;
  logic signed [DLY_W-1:0]  d_sat;

  always_comb begin
    unique case (ctrl_i.coef_sel)
      bqd_pkg::SEL_A0: coef = coef_i[bqd_pkg::REG_A0];
      bqd_pkg::SEL_A1: coef = coef_i[bqd_pkg::REG_A1];
      bqd_pkg::SEL_A2: coef = coef_i[bqd_pkg::REG_A2];
      bqd_pkg::SEL_B1: coef = coef_i[bqd_pkg::REG_B1];
      bqd_pkg::SEL_B2: coef = coef_i[bqd_pkg::REG_B2];
      default:         coef = '0;
    endcase
  end

  assign opd   = (ctrl_i.opd_sel == bqd_pkg::OPD_Y) ? y_q : x_q;
  assign p_ext = ACC_W'(p_q);

  always_comb begin
    unique case (ctrl_i.acc_op)
      bqd_pkg::ACC_HOLD:    acc_d = acc_q;
      bqd_pkg::ACC_LOAD_D1: acc_d = ACC_W'(d1_q) + p_ext;
      bqd_pkg::ACC_LOAD_D2: acc_d = ACC_W'(d2_q) + p_ext;
      bqd_pkg::ACC_LOAD_P:  acc_d = p_ext;
      bqd_pkg::ACC_SUB_P:   acc_d = acc_q - p_ext;
      default:              acc_d = acc_q;
    endcase
  end

  // round half up, then saturate to the sample range
  assign rnd   = acc_q + HALF;
  assign ysh   = rnd >>> CFB;
  assign y_ovf = !((&ysh[ACC_W-1:SW-1]) || !(|ysh[ACC_W-1:SW-1]));
  assign y_sat = y_ovf ? (ysh[ACC_W-1] ? Y_MIN : Y_MAX) : ysh[SW-1:0];

  // delay saturation
  always_comb begin
    if ((&acc_q[ACC_W-1:DLY_W-1]) || !(|acc_q[ACC_W-1:DLY_W-1])) begin
      d_sat = acc_q[DLY_W-1:0];
    end else begin
      d_sat = acc_q[ACC_W-1] ? D_MIN : D_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_x) begin
      x_q <= sample_i;
    end
    if (ctrl_i.mul_en) begin
      p_q <= coef * opd;
    end
    acc_q <= acc_d;
    if (ctrl_i.y_wr) begin
      y_q    <= y_sat;
      clip_q <= y_ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q <= '0;
      d2_q <= '0;
    end else if (ctrl_i.clr_dly) begin
      d1_q <= '0;
      d2_q <= '0;
    end else begin
      if (ctrl_i.d1_wr) begin
        d1_q <= d_sat;
      end
      if (ctrl_i.d2_wr) begin
        d2_q <= d_sat;
      end
    end
  end

  assign y_o    = y_q;
  assign clip_o = clip_q;

endmodule

>>> rtl/biquad_decimate_by_two_top.sv
// biquad low-pass decimator: program sequencer, coefficient registers, output register
//
// input stream: s_axis_tdata carries one signed sample, s_axis_tlast marks the
// last sample of a signal; after that sample both delays and the decimation
// phase return to zero. output stream: m_axis_tdata carries the filtered,
// rounded and saturated sample, m_axis_tuser flags saturation. one output beat
// comes for the first of every DECIMATION input beats.
// each sample runs a 9-step control program on one shared multiplier:
// s_axis_tready is high only in the idle step, so a new sample is accepted only
// once the previous one has run its last step, where any output beat is registered.
// the output register holds a finished beat while the next sample is worked;
// when a new result is due and the receiver still stalls the previous one,
// the last step waits until the output register frees.
// coefficients are written over the apb port (a0, a1, a2, b1, b2 at byte
// addresses 0, 4, 8, 12, 16); the user must write them only while the block
// is idle (the block does not enforce this); reads return them sign extended.
// reset clears the delays, the phase and the output valid, and loads the
// default coefficients.
module biquad_decimate_by_two_top #(
  parameter int SAMPLE_WIDTH   = bqd_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = bqd_pkg::COEF_FRAC_BITS_DEF,
  parameter int DECIMATION     = bqd_pkg::DECIMATION_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       s_axis_tdata,  // sample_in
  input  logic                                    s_axis_tlast,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       m_axis_tdata,  // filtered_out
  output logic                                    m_axis_tuser,  // clipped
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [bqd_pkg::PADDR_W-1:0]             paddr,
  input  logic [bqd_pkg::PDATA_W-1:0]             pwdata,
  output logic [bqd_pkg::PDATA_W-1:0]             prdata,
  output logic                                    pready
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int TD_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int PH_W = $clog2(DECIMATION);
  localparam int CW   = bqd_pkg::COEF_W;

  logic signed [CW-1:0]               coef_q [bqd_pkg::NUM_COEF];
  logic [bqd_pkg::STEP_W-1:0]         step_q;
  logic [PH_W-1:0]                    phase_q;
  logic                               last_q;
  logic                               out_vld_q;
  logic [SW-1:0]                      out_data_q;
  logic                               out_clip_q;

  bqd_pkg::uword_t                    uw;
  bqd_pkg::dp_ctrl_t                  ctrl;
  bqd_pkg::reg_idx_e                  reg_idx;
  logic                               in_fire;
  logic                               emit;
  logic                               stall;
  logic                               go;
  logic                               cfg_wr;
  logic signed [SW-1:0]               y;
  logic                               clip;

  assign uw      = bqd_pkg::ucode(step_q);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign emit    = (phase_q == '0);
  assign stall   = uw.finish && emit && out_vld_q && !m_axis_tready;
  assign go      = uw.wait_in ? in_fire : !stall;

  always_comb begin
    ctrl          = '0;
    ctrl.coef_sel = uw.coef_sel;
    ctrl.opd_sel  = uw.opd_sel;
    ctrl.acc_op   = bqd_pkg::ACC_HOLD;
    if (go) begin
      ctrl.ld_x    = uw.wait_in;
      ctrl.mul_en  = uw.mul_en;
      ctrl.acc_op  = uw.acc_op;
      ctrl.y_wr    = uw.y_wr;
      ctrl.d1_wr   = uw.d1_wr;
      ctrl.d2_wr   = uw.d2_wr;
      ctrl.clr_dly = uw.finish && last_q;
    end
  end

  bqd_datapath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_bqd_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (s_axis_tdata[SW-1:0]),
    .coef_i   (coef_q),
    .y_o      (y),
    .clip_o   (clip)
  );

  // sequencer, phase and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= '0;
      phase_q   <= '0;
      last_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (go) begin
        if (uw.wait_in) begin
          last_q <= s_axis_tlast;
        end
        if (uw.finish) begin
          step_q <= '0;
          if (emit) begin
            out_vld_q <= 1'b1;
          end
          if (last_q || phase_q == PH_W'(DECIMATION - 1)) begin
            phase_q <= '0;
          end else begin
            phase_q <= phase_q + 1'b1;
          end
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && uw.finish && emit) begin
      out_data_q <= y;
      out_clip_q <= clip;
    end
  end

  assign s_axis_tready = uw.wait_in;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = TD_W'(out_data_q);
  assign m_axis_tuser  = out_clip_q;

  // apb coefficient registers
  assign reg_idx = bqd_pkg::reg_idx_e'(paddr[bqd_pkg::PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= bqd_pkg::COEF_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        bqd_pkg::REG_A0: coef_q[bqd_pkg::REG_A0] <= pwdata[CW-1:0];
        bqd_pkg::REG_A1: coef_q[bqd_pkg::REG_A1] <= pwdata[CW-1:0];
        bqd_pkg::REG_A2: coef_q[bqd_pkg::REG_A2] <= pwdata[CW-1:0];
        bqd_pkg::REG_B1: coef_q[bqd_pkg::REG_B1] <= pwdata[CW-1:0];
        bqd_pkg::REG_B2: coef_q[bqd_pkg::REG_B2] <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bqd_pkg::REG_A0: prdata = bqd_pkg::PDATA_W'(coef_q[bqd_pkg::REG_A0]);
      bqd_pkg::REG_A1: prdata = bqd_pkg::PDATA_W'(coef_q[bqd_pkg::REG_A1]);
      bqd_pkg::REG_A2: prdata = bqd_pkg::PDATA_W'(coef_q[bqd_pkg::REG_A2]);
      bqd_pkg::REG_B1: prdata = bqd_pkg::PDATA_W'(coef_q[bqd_pkg::REG_B1]);
      bqd_pkg::REG_B2: prdata = bqd_pkg::PDATA_W'(coef_q[bqd_pkg::REG_B2]);
      default:         prdata = '0;
    endcase
  end

endmodule
